### rtl/mas_pkg.sv
// Shared constants, register codes and controller states for the moving average smoother.
package mas_pkg;

  localparam int WINDOW_MAX_DEF       = 64;
  localparam int SAMPLE_BITS_DEF      = 32;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;

  localparam int MODE_BITS  = 2;
  localparam int COUNT_BITS = 7;
  localparam int WEIGHT_BITS = 16;
  localparam int INDEX_BITS = 2;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_TRAILING = 2'd0,
    MODE_CENTERED = 2'd1,
    MODE_EXP      = 2'd2,
    MODE_SPARE    = 2'd3
  } mode_t;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_MODE   = 2'd0,
    REG_COUNT  = 2'd1,
    REG_WEIGHT = 2'd2,
    REG_SEED   = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    STAT_NONE  = 2'd0,
    STAT_PLAIN = 2'd1,
    STAT_TREND = 2'd2,
    STAT_SPARE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SUM,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

endpackage

### rtl/moving_average_smoother.sv
// Top level of the moving average smoother: history memory, summing sequencer, divider and exponential step.
//
//  channel | signals                                          | direction
//  input   | in_valid, in_stall, sample, series_start         | in, stall out
//  output  | out_valid, out_stall, referred_sample, trend,    | out, stall in
//          | residual, result_status                          |
//  config  | cfg_we, cfg_index, cfg_data                      | in
//
// Each word is accepted, decoded and loaded into the output register, with the
// history sweep and the divider between: a mean reads R = N or N+1 history
// entries, one per cycle from the single read port; a mean with a trend then
// runs a bit-serial divide. An exponential step passes through a multiply and
// an add state, a register-seeded first step goes from decode to output, and
// the step seeded from the mean of the first N words runs the divide.
// rst is synchronous; no clearing pass is needed. A waiting result holds in the
// output register while the next word is accepted.
module moving_average_smoother #(
  parameter int WINDOW_MAX       = mas_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS      = mas_pkg::SAMPLE_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = mas_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  input  logic                              series_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     referred_sample,
  output logic signed [SAMPLE_BITS-1:0]     trend,
  output logic signed [SAMPLE_BITS-1:0]     residual,
  output logic [1:0]                        result_status,
  input  logic                              cfg_we,
  input  logic [mas_pkg::INDEX_BITS-1:0]    cfg_index,
  input  logic [((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16)-1:0] cfg_data
);

  localparam int SB       = SAMPLE_BITS;
  localparam int HD       = 2 * WINDOW_MAX;
  localparam int AW       = $clog2(HD);
  localparam int SEEN_MAX = 2 * WINDOW_MAX + 1;
  localparam int SW       = $clog2(SEEN_MAX + 1);
  localparam int NSW      = $clog2(WINDOW_MAX + 1);
  localparam int JW       = $clog2(WINDOW_MAX + 2);
  localparam int XW       = (NSW > mas_pkg::COUNT_BITS) ? NSW : mas_pkg::COUNT_BITS;
  localparam int SUM_W    = SB + $clog2(HD) + 1;
  localparam int RS_W     = SB + $clog2(WINDOW_MAX) + 1;
  localparam int DV_W     = $clog2(2 * WINDOW_MAX + 1);
  localparam int DC_W     = $clog2(SUM_W + 1);
  localparam int WB       = (WEIGHT_FRAC_BITS + 1 > mas_pkg::WEIGHT_BITS) ?
                            WEIGHT_FRAC_BITS + 1 : mas_pkg::WEIGHT_BITS;
  localparam int PW       = WB + SB + 2;

  // configuration registers
  mas_pkg::mode_t                 smoother_mode;
  logic [mas_pkg::COUNT_BITS-1:0] sample_count;
  logic [mas_pkg::WEIGHT_BITS-1:0] ema_weight;
  logic signed [SB-1:0]           ema_seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      smoother_mode <= mas_pkg::MODE_CENTERED;
      sample_count  <= mas_pkg::COUNT_BITS'(3);
      ema_weight    <= mas_pkg::WEIGHT_BITS'(6554);
      ema_seed      <= '0;
    end else if (cfg_we) begin
      unique case (mas_pkg::reg_index_t'(cfg_index))
        mas_pkg::REG_MODE:   smoother_mode <= mas_pkg::mode_t'(cfg_data[mas_pkg::MODE_BITS-1:0]);
        mas_pkg::REG_COUNT:  sample_count  <= cfg_data[mas_pkg::COUNT_BITS-1:0];
        mas_pkg::REG_WEIGHT: ema_weight    <= cfg_data[mas_pkg::WEIGHT_BITS-1:0];
        mas_pkg::REG_SEED:   ema_seed      <= cfg_data[SB-1:0];
        default: ;
      endcase
    end
  end

  // decoded configuration
  logic           is_exp, is_centered;
  logic [NSW-1:0] n_sat, n_mean, lag;
  logic [WB-1:0]  w_sat;

  always_comb begin
    is_exp      = (smoother_mode == mas_pkg::MODE_EXP);
    is_centered = (smoother_mode == mas_pkg::MODE_CENTERED);
    if (XW'(sample_count) > XW'(WINDOW_MAX)) n_sat = NSW'(WINDOW_MAX);
    else n_sat = NSW'(sample_count);
    n_mean = (n_sat == '0) ? NSW'(1) : n_sat;
    lag    = is_centered ? (n_mean >> 1) : '0;
    if (WB'(ema_weight) > WB'(2 ** WEIGHT_FRAC_BITS)) w_sat = WB'(2 ** WEIGHT_FRAC_BITS);
    else w_sat = WB'(ema_weight);
  end

  // controller and datapath registers
  mas_pkg::state_t state, state_next;
  logic [AW-1:0]          history_pointer, newest;
  logic [SW-1:0]          samples_seen, item_i;
  logic signed [RS_W-1:0] running_sum;
  logic signed [SB-1:0]   ema_value, x;
  logic signed [SB-1:0]   ref_val, trend_val;
  mas_pkg::status_t       status;
  logic [JW-1:0]          issue_j, rd_j, last_j;
  logic                   rd_pend;
  logic signed [SUM_W-1:0] acc;
  logic [SUM_W-1:0]       div_quot;
  logic [DV_W:0]          div_rem;
  logic [DV_W-1:0]        divisor;
  logic                   div_neg, div_to_ema;
  logic [DC_W-1:0]        div_cnt;
  logic signed [PW-1:0]   prod;

  // history memory
  logic signed [SB-1:0] history [HD];
  logic signed [SB-1:0] rdata;
  logic [AW-1:0]        raddr;
  logic [AW:0]          raddr_diff;

  logic accept;
  assign accept = in_valid && !in_stall;

  always_comb begin
    raddr_diff = {1'b0, newest} - (AW + 1)'(issue_j);
    if (raddr_diff[AW]) raddr = AW'(raddr_diff + (AW + 1)'(HD));
    else raddr = raddr_diff[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) history[history_pointer] <= sample;
    rdata <= history[raddr];
  end

  // decisions taken when the word is decoded, when the sweep ends and when the divide ends
  logic [SW:0] i_plus1;
  logic        mean_has_trend, even_centered, sum_last, div_last;
  assign i_plus1        = {1'b0, item_i} + (SW + 1)'(1);
  assign even_centered  = is_centered && !n_mean[0];
  assign mean_has_trend = even_centered ? (item_i >= SW'(n_mean))
                                        : (i_plus1 >= (SW + 1)'(n_mean));
  assign sum_last       = rd_pend && (rd_j == last_j);
  assign div_last       = (div_cnt == DC_W'(SUM_W - 1));

  // divider step
  logic [DV_W+1:0] rem_shift, rem_sub;
  assign rem_shift = {div_rem, div_quot[SUM_W-1]};
  assign rem_sub   = rem_shift - (DV_W + 2)'(divisor);

  logic [SUM_W-1:0] div_q_fin;
  logic [SUM_W-1:0] quot_step;
  logic             step_bit;
  always_comb begin
    step_bit  = !rem_sub[DV_W+1];
    quot_step = {div_quot[SUM_W-2:0], step_bit};
    div_q_fin = div_neg ? ~quot_step : quot_step;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mas_pkg::ST_IDLE:   if (accept) state_next = mas_pkg::ST_DECODE;
      mas_pkg::ST_DECODE: begin
        if (is_exp) begin
          if (n_sat == '0) state_next = (item_i == '0) ? mas_pkg::ST_DONE : mas_pkg::ST_MUL;
          else if (i_plus1 < (SW + 1)'(n_sat)) state_next = mas_pkg::ST_DONE;
          else if (i_plus1 == (SW + 1)'(n_sat)) state_next = mas_pkg::ST_DIV;
          else state_next = mas_pkg::ST_MUL;
        end else if (item_i < SW'(lag)) begin
          state_next = mas_pkg::ST_DONE;
        end else begin
          state_next = mas_pkg::ST_SUM;
        end
      end
      mas_pkg::ST_SUM:    if (sum_last) state_next = mean_has_trend ? mas_pkg::ST_DIV
                                                                     : mas_pkg::ST_DONE;
      mas_pkg::ST_DIV:    if (div_last) state_next = mas_pkg::ST_DONE;
      mas_pkg::ST_MUL:    state_next = mas_pkg::ST_ADD;
      mas_pkg::ST_ADD:    state_next = mas_pkg::ST_DONE;
      mas_pkg::ST_DONE:   if (!out_valid || !out_stall) state_next = mas_pkg::ST_IDLE;
      default:            state_next = mas_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  logic load_out;
  always_comb begin
    in_stall = (state != mas_pkg::ST_IDLE);
    load_out = (state == mas_pkg::ST_DONE) && (!out_valid || !out_stall);
  end

  logic [SW-1:0]          i_acc;
  logic signed [RS_W-1:0] rs_base;
  logic signed [SUM_W-1:0] term;
  logic signed [SB:0]     diff, res_full;
  assign i_acc   = series_start ? '0 : samples_seen;
  assign rs_base = series_start ? '0 : running_sum;
  assign diff    = {x[SB-1], x} - {ema_value[SB-1], ema_value};
  assign res_full = {ref_val[SB-1], ref_val} - {trend_val[SB-1], trend_val};

  always_comb begin
    term = SUM_W'(rdata);
    if (even_centered && rd_j != '0 && rd_j != last_j) term = term <<< 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= mas_pkg::ST_IDLE;
      history_pointer <= '0;
      samples_seen    <= '0;
      running_sum     <= '0;
      ema_value       <= '0;
      out_valid       <= 1'b0;
      rd_pend         <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (state)
        mas_pkg::ST_IDLE: if (accept) begin
          newest          <= history_pointer;
          history_pointer <= (history_pointer == AW'(HD - 1)) ? '0 : history_pointer + 1'b1;
          item_i          <= i_acc;
          samples_seen    <= (i_acc < SW'(SEEN_MAX)) ? i_acc + 1'b1 : i_acc;
          x               <= sample;
          if (is_exp && i_acc < SW'(WINDOW_MAX)) running_sum <= rs_base + RS_W'(sample);
          else running_sum <= rs_base;
        end
        mas_pkg::ST_DECODE: begin
          issue_j  <= '0;
          rd_pend  <= 1'b0;
          acc      <= '0;
          ref_val  <= is_exp ? x : '0;
          // only the register-seeded first step keeps this value
          trend_val <= ema_seed;
          if (!is_exp) status <= mas_pkg::STAT_NONE;
          else if (n_sat != '0 && i_plus1 < (SW + 1)'(n_sat)) status <= mas_pkg::STAT_PLAIN;
          else status <= mas_pkg::STAT_TREND;
          last_j   <= even_centered ? JW'(n_mean) : JW'(n_mean) - 1'b1;
          div_cnt  <= '0;
          div_rem  <= '0;
          div_to_ema <= 1'b1;
          if (is_exp) begin
            if (n_sat == '0) begin
              if (item_i == '0) ema_value <= ema_seed;
            end else if (i_plus1 >= (SW + 1)'(n_sat)) begin
              // seed from the mean of the first N words
              div_neg  <= running_sum[RS_W-1];
              div_quot <= running_sum[RS_W-1] ? ~SUM_W'(running_sum) : SUM_W'(running_sum);
              divisor  <= DV_W'(n_sat);
            end
          end
        end
        mas_pkg::ST_SUM: begin
          if (issue_j <= last_j) begin
            issue_j <= issue_j + 1'b1;
            rd_pend <= 1'b1;
            rd_j    <= issue_j;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            acc <= acc + term;
            if (rd_j == JW'(lag)) ref_val <= rdata;
          end
          if (sum_last) begin
            status     <= mas_pkg::STAT_PLAIN;
            div_to_ema <= 1'b0;
            div_neg    <= (acc + term) < 0;
            div_quot   <= ((acc + term) < 0) ? ~(acc + term) : (acc + term);
            divisor    <= even_centered ? (DV_W'(n_mean) << 1) : DV_W'(n_mean);
          end
        end
        mas_pkg::ST_DIV: begin
          div_cnt  <= div_cnt + 1'b1;
          div_quot <= quot_step;
          div_rem  <= step_bit ? rem_sub[DV_W:0] : rem_shift[DV_W:0];
          if (div_last) begin
            trend_val <= SB'(div_q_fin);
            status    <= mas_pkg::STAT_TREND;
            if (div_to_ema) ema_value <= SB'(div_q_fin);
          end
        end
        mas_pkg::ST_MUL: prod <= PW'($signed({1'b0, w_sat})) * PW'(diff);
        mas_pkg::ST_ADD: begin
          ema_value <= ema_value + SB'(prod >>> WEIGHT_FRAC_BITS);
          trend_val <= ema_value + SB'(prod >>> WEIGHT_FRAC_BITS);
        end
        mas_pkg::ST_DONE: if (load_out) begin
          referred_sample <= ref_val;
          trend           <= (status == mas_pkg::STAT_TREND) ? trend_val : '0;
          result_status   <= status;
          if (status != mas_pkg::STAT_TREND) residual <= '0;
          else if (res_full[SB] != res_full[SB-1])
            residual <= res_full[SB] ? {1'b1, {(SB - 1){1'b0}}} : {1'b0, {(SB - 1){1'b1}}};
          else residual <= res_full[SB-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule

### dv/moving_average_smoother_tb.sv
// Self-checking testbench for the moving average smoother: random stalls, config phases.
module moving_average_smoother_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_DEPTH = 2 * mas_pkg::WINDOW_MAX_DEF;
  localparam int SEEN_MAX   = 2 * mas_pkg::WINDOW_MAX_DEF + 1;
  localparam int LIMIT      = 3000000;
  localparam int DRAIN      = 200;

  typedef struct {
    logic signed [31:0] x;
    logic               start;
  } word_t;

  typedef struct {
    logic signed [31:0] ref_smp;
    logic signed [31:0] trend_v;
    logic signed [31:0] resid;
    mas_pkg::status_t   stat;
  } smooth_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] sample = 0;
  logic series_start = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] referred_sample, trend, residual;
  logic [1:0] result_status;
  logic cfg_we = 0;
  logic [mas_pkg::INDEX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  moving_average_smoother uut (.*);

  word_t   pending_words[$];
  smooth_t expected_smooth[$];
  int errors = 0;
  int cycles = 0;
  int send_gap = 0, stall_left = 0;
  logic in_took = 0, out_took = 0;
  logic burst = 0;
  logic rx_hold_request = 0;

  // shadow registers and predictor state
  mas_pkg::mode_t sh_mode;
  int unsigned sh_count, sh_weight;
  logic [31:0] sh_seed;
  longint      hist[HIST_DEPTH];
  int unsigned hist_ptr, seen;
  longint      run_sum, ema;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint hist_back(int unsigned newest, int unsigned j);
    return hist[(newest + HIST_DEPTH - (j % HIST_DEPTH)) % HIST_DEPTH];
  endfunction

  task automatic predict_smooth(input logic signed [31:0] sx, input logic st);
    longint x, r, t, s, w;
    int unsigned newest, i, n, lag, j;
    mas_pkg::status_t stat;
    smooth_t e;
    x = sx; r = 0; t = 0; s = 0; lag = 0; stat = mas_pkg::STAT_NONE;
    if (st) begin
      seen = 0;
      run_sum = 0;
    end
    i = seen;
    newest = hist_ptr;
    hist[newest] = x;
    hist_ptr = (newest + 1) % HIST_DEPTH;
    if (seen < SEEN_MAX) seen++;
    n = (sh_count > mas_pkg::WINDOW_MAX_DEF) ? mas_pkg::WINDOW_MAX_DEF : sh_count;
    if (sh_mode == mas_pkg::MODE_EXP) begin
      w = (sh_weight > 65536) ? 65536 : sh_weight;
      if (i < mas_pkg::WINDOW_MAX_DEF) run_sum += x;
      r = x;
      stat = mas_pkg::STAT_TREND;
      if (n == 0) begin
        if (i == 0) ema = longint'($signed(sh_seed));
        else ema += floor_div(w * (x - ema), 65536);
      end else if (i + 1 < n) begin
        stat = mas_pkg::STAT_PLAIN;
      end else if (i + 1 == n) begin
        ema = floor_div(run_sum, n);
      end else begin
        ema += floor_div(w * (x - ema), 65536);
      end
      if (stat == mas_pkg::STAT_TREND) t = ema;
    end else begin
      if (n < 1) n = 1;
      if (sh_mode == mas_pkg::MODE_CENTERED) lag = n / 2;
      if (i >= lag) begin
        r = hist_back(newest, lag);
        stat = mas_pkg::STAT_PLAIN;
        if (sh_mode == mas_pkg::MODE_CENTERED && (n % 2) == 0) begin
          if (i >= n) begin
            s = hist_back(newest, 0) + hist_back(newest, n);
            for (j = 1; j < n; j++) s += 2 * hist_back(newest, j);
            t = floor_div(s, 2 * n);
            stat = mas_pkg::STAT_TREND;
          end
        end else if (i + 1 >= n) begin
          for (j = 0; j < n; j++) s += hist_back(newest, j);
          t = floor_div(s, n);
          stat = mas_pkg::STAT_TREND;
        end
      end
    end
    e.ref_smp = r[31:0];
    e.trend_v = t[31:0];
    e.resid   = (stat == mas_pkg::STAT_TREND) ? sat32(r - t) : 0;
    e.stat    = stat;
    expected_smooth.push_back(e);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
  endtask

  // accept side: predict on every input word, check every output word
  always @(posedge clk) begin
    smooth_t e;
    in_took  <= in_valid && !in_stall && !rst;
    out_took <= out_valid && !out_stall && !rst;
    if (!rst && in_valid && !in_stall) predict_smooth(sample, series_start);
    if (!rst && out_valid && !out_stall) begin
      if (expected_smooth.size() == 0) begin
        report("unexpected word", referred_sample, 0);
      end else begin
        e = expected_smooth.pop_front();
        if (referred_sample !== e.ref_smp) report("referred_sample", referred_sample, e.ref_smp);
        if (trend !== e.trend_v) report("trend", trend, e.trend_v);
        if (residual !== e.resid) report("residual", residual, e.resid);
        if (result_status !== e.stat) report("result_status", result_status, e.stat);
      end
    end
  end

  // driver
  always @(negedge clk) begin
    word_t w;
    if (rst) begin
      in_valid <= 0;
    end else if (in_valid && !in_took) begin
      // hold the stalled word
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 0;
    end else if (pending_words.size() > 0) begin
      w = pending_words.pop_front();
      sample       <= w.x;
      series_start <= w.start;
      in_valid     <= 1;
      send_gap     <= burst ? 0 : $urandom_range(0, 12);
    end else begin
      in_valid <= 0;
    end
  end

  // receiver
  always @(negedge clk) begin
    int cnt;
    cnt = out_took ? (burst ? 0 : $urandom_range(0, 12)) : stall_left;
    out_stall  <= rx_hold_request || cnt > 0;
    stall_left <= (cnt > 0) ? cnt - 1 : 0;
  end

  // long receiver hold-off, counted here
  always begin
    wait (rx_hold_request);
    repeat (600) @(negedge clk);
    rx_hold_request = 0;
  end

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 8) - 4;
      3: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(input logic [31:0] x, input logic st);
    word_t w;
    w.x = x;
    w.start = st;
    pending_words.push_back(w);
  endtask

  task automatic wait_idle();
    wait (pending_words.size() == 0 && !in_valid && expected_smooth.size() == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input mas_pkg::reg_index_t idx, input logic [31:0] v);
    @(negedge clk);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      mas_pkg::REG_MODE:   sh_mode   = mas_pkg::mode_t'(v[1:0]);
      mas_pkg::REG_COUNT:  sh_count  = v[6:0];
      mas_pkg::REG_WEIGHT: sh_weight = v[15:0];
      mas_pkg::REG_SEED:   sh_seed   = v;
      default: ;
    endcase
  endtask

  task automatic run_series(input int count, input logic first_start);
    for (int k = 0; k < count; k++)
      push_word(rand_sample(), (k == 0) ? first_start : ($urandom_range(0, 39) == 0));
  endtask

  initial begin
    int total, count_pick;
    sh_mode = mas_pkg::MODE_CENTERED; sh_count = 3; sh_weight = 6554; sh_seed = 0;
    hist_ptr = 0; seen = 0; run_sum = 0; ema = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 0;

    // directed: reset settings, no series start yet, field extremes
    push_word(32'h7fffffff, 0);
    push_word(32'h80000000, 0);
    push_word(32'h7fffffff, 0);
    push_word(32'h80000000, 0);
    push_word(32'h0, 0);
    push_word(32'hffffffff, 1);
    push_word(32'h00010000, 0);
    push_word(32'h55555555, 0);
    push_word(32'haaaaaaaa, 0);
    wait_idle();
    // exponential seeded from register, extreme weight and seed
    write_reg(mas_pkg::REG_MODE, mas_pkg::MODE_EXP);
    write_reg(mas_pkg::REG_COUNT, 0);
    write_reg(mas_pkg::REG_WEIGHT, 65535);
    write_reg(mas_pkg::REG_SEED, 32'h80000000);
    push_word(32'h7fffffff, 1);
    push_word(32'h80000000, 0);
    push_word(32'h7fffffff, 0);
    wait_idle();
    write_reg(mas_pkg::REG_WEIGHT, 66);
    write_reg(mas_pkg::REG_SEED, 32'h7fffffff);
    push_word(32'h80000000, 1);
    push_word(32'h0, 0);
    wait_idle();
    // oversized window saturates, run past the history depth
    write_reg(mas_pkg::REG_MODE, mas_pkg::MODE_SPARE);
    write_reg(mas_pkg::REG_COUNT, 127);
    run_series(140, 1);
    wait_idle();
    // even centered window at its maximum; receiver holds off meanwhile
    write_reg(mas_pkg::REG_MODE, mas_pkg::MODE_CENTERED);
    write_reg(mas_pkg::REG_COUNT, 64);
    rx_hold_request = 1;
    run_series(140, 1);
    wait_idle();
    total = 0;

    while (total < 1650) begin
      burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1)) write_reg(mas_pkg::REG_MODE, $urandom_range(0, 3));
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 6))
          0: count_pick = $urandom_range(0, 1);
          1: count_pick = $urandom_range(63, 127);
          2: count_pick = $urandom_range(0, 127) | 32'hffffff80;
          default: count_pick = $urandom_range(2, 8);
        endcase
        write_reg(mas_pkg::REG_COUNT, count_pick);
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(mas_pkg::REG_WEIGHT,
                  $urandom_range(0, 1) ? $urandom_range(66, 65470) : $urandom);
      if ($urandom_range(0, 2) == 0) write_reg(mas_pkg::REG_SEED, rand_sample());
      if ($urandom_range(0, 7) == 0)
        write_reg(mas_pkg::reg_index_t'($urandom_range(0, 3)), $urandom);
      count_pick = $urandom_range(20, 80);
      run_series(count_pick, $urandom_range(0, 1));
      total += count_pick;
      wait_idle();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/mas_pkg.sv
rtl/moving_average_smoother.sv
dv/moving_average_smoother_tb.sv
